// ===== design/heat_diffusion_stencil_sweep_macros.svh =====
// Assertion helpers for the stencil sweep design file.
`ifndef HEAT_DIFFUSION_STENCIL_SWEEP_MACROS_SVH
`define HEAT_DIFFUSION_STENCIL_SWEEP_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define HDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stencil assertion failed");
// Next-cycle implication, disabled during reset
`define HDS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stencil assertion failed");
`else
`define HDS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HDS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/hds_pkg.sv =====
package hds_pkg;

  // Default sizing
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;
  localparam int VALUE_BITS_DEF = 16;

  // Fixed field widths
  localparam int VALUE_W    = 16;
  localparam int POS_W      = 12;
  localparam int CFG_DATA_W = 13;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  // Smallest legal grid edge
  localparam int MIN_SIZE = 3;

  // Register indexes
  typedef enum logic [0:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  // Clamp a written size to [MIN_SIZE, max_size] and return size minus one
  function automatic int size_last(input logic [CFG_DATA_W-1:0] v, input int max_size);
    int s;
    s = int'(v);
    if (s < MIN_SIZE) begin
      s = MIN_SIZE;
    end else if (s > max_size) begin
      s = max_size;
    end
    return s - 1;
  endfunction

endpackage

// ===== design/hds_ram.sv =====
module hds_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/heat_diffusion_stencil_sweep.sv =====
// Channel  Direction  Payload (low bit up)                             Side band
// in_      slave      tdata: cell_value[15:0]                          -
// out_     master     tdata: new_value[15:0] column[27:16] row[39:28]  tlast: last_of_sweep
// cfg_     write      index 0 grid_width, index 1 grid_height           -
//
// One cell beat is accepted per cycle unless stage 1 holds the input; a result leaves after its
// closing cell passes the line-buffer read register, then the output register.
// Each line-buffer RAM has separate read and write ports, so one read and one write per cycle.
// rst_n is synchronous, active low; it clears counters and valid flags, and the line buffers
// keep no reset. A stalled output holds its beat; cells keep entering until one that
// completes a stencil waits in stage 1, which then holds the input.
`include "heat_diffusion_stencil_sweep_macros.svh"

module heat_diffusion_stencil_sweep #(
  parameter int MAX_WIDTH  = hds_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hds_pkg::MAX_HEIGHT_DEF,
  parameter int VALUE_BITS = hds_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input cells: [15:0] cell_value
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hds_pkg::IN_DATA_W-1:0]    in_tdata,
  // Results: [15:0] new_value, [27:16] column, [39:28] row
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hds_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tlast,
  // Configuration
  input  logic                             cfg_we,
  input  hds_pkg::cfg_reg_t                cfg_index,
  input  logic [hds_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import hds_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SW = VALUE_BITS + 3;
  localparam int RST_W = (4096 < MAX_WIDTH)  ? 4096 : MAX_WIDTH;
  localparam int RST_H = (4096 < MAX_HEIGHT) ? 4096 : MAX_HEIGHT;

  // Size limits (last column and last row)
  logic [CW-1:0] col_last_r;
  logic [RW-1:0] row_last_r;

  // Raster position of the next cell
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // Stage 1: cell waiting for its line-buffer reads
  logic                  s1_valid_r;
  logic [VALUE_BITS-1:0] s1_cell_r;
  logic [CW-1:0]         s1_col_r;
  logic [RW-1:0]         s1_row_r;

  // Stencil window
  logic [VALUE_BITS-1:0] win_up_r, win_left_r, win_centre_r, win_down_r;

  // Output register
  logic                  out_valid_r;
  logic [VALUE_W-1:0]    out_value_r;
  logic [POS_W-1:0]      out_col_r;
  logic [POS_W-1:0]      out_row_r;
  logic                  out_last_r;

  logic                  in_beat;
  logic                  s1_produce;
  logic                  s1_adv;
  logic [VALUE_BITS-1:0] above_rd, middle_rd;
  logic [VALUE_BITS-1:0] in_cell;
  logic [SW-1:0]         sum;

  assign in_cell = VALUE_BITS'(in_tdata[VALUE_W-1:0]);

  // Handshake: stage 1 moves on when its result has room or it has none
  assign s1_produce = (s1_row_r >= RW'(2)) && (s1_col_r >= CW'(2));
  assign s1_adv     = s1_valid_r && (!s1_produce || !out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign in_beat    = in_tvalid && in_tready;

  // Line buffers
  hds_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIDTH)) u_above (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (middle_rd),
    .re    (in_beat),
    .raddr (col_r),
    .rdata (above_rd)
  );

  hds_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata (s1_cell_r),
    .re    (in_beat),
    .raddr (col_r),
    .rdata (middle_rd)
  );

  // Advance the raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_beat) begin
      if (col_r == col_last_r) begin
        col_nxt = '0;
        row_nxt = (row_r == row_last_r) ? '0 : RW'(row_r + 1'b1);
      end else begin
        col_nxt = CW'(col_r + 1'b1);
      end
    end
  end

  // Size registers and counters; a write restarts the sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_last_r <= CW'(RST_W - 1);
      row_last_r <= RW'(RST_H - 1);
      col_r      <= '0;
      row_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  col_last_r <= CW'(size_last(cfg_data, MAX_WIDTH));
        CFG_GRID_HEIGHT: row_last_r <= RW'(size_last(cfg_data, MAX_HEIGHT));
        default: ;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1 valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_beat) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_cell_r <= in_cell;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
    end
  end

  // Weighted stencil sum: 4*centre plus the four neighbors
  assign sum = SW'({win_centre_r, 2'b00}) + SW'(win_left_r) + SW'(middle_rd)
             + SW'(win_up_r) + SW'(win_down_r);

  // Shift the window
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_up_r     <= above_rd;
      win_left_r   <= win_centre_r;
      win_centre_r <= middle_rd;
      win_down_r   <= s1_cell_r;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_produce) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (s1_adv && s1_produce) begin
      out_value_r <= VALUE_W'(sum[SW-1:3]);
      out_col_r   <= POS_W'(s1_col_r - 1'b1);
      out_row_r   <= POS_W'(s1_row_r - 1'b1);
      out_last_r  <= (s1_col_r == col_last_r) && (s1_row_r == row_last_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_row_r, out_col_r, out_value_r};
  assign out_tlast  = out_last_r;

  // An accepted cell always lands in stage 1
  `HDS_ASSERT_NXT(a_s1_fill, clk, rst_n, in_beat, s1_valid_r)
  // An empty stage 1 never blocks the input
  `HDS_ASSERT_IMP(a_ready_empty, clk, rst_n, !s1_valid_r, in_tready)
  // Cells of the first row or first column never leave the block
  `HDS_ASSERT_IMP(a_no_border, clk, rst_n, out_valid_r, (out_col_r != '0) && (out_row_r != '0))
  // The sweep ends on the last interior column
  `HDS_ASSERT_IMP(a_last_col, clk, rst_n, out_valid_r && out_last_r,
                  out_col_r == POS_W'(col_last_r - 1'b1))

endmodule
